/* hw/rtl/imu_complementary_attitude_top_macros.svh */
// Assertion macros shared by the attitude estimator RTL.
// Each file that asserts includes this header; every macro assumes i_clk and i_rst_n.
`ifndef IMU_COMPLEMENTARY_ATTITUDE_TOP_MACROS_SVH
`define IMU_COMPLEMENTARY_ATTITUDE_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define IMUCA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define IMUCA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/imuca_pkg.sv */
// Package for the attitude estimator: payload structs, CORDIC interface types,
// fixed-point constants, the arctangent table and wrapping and clamping helpers. No dependencies.
package imuca_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam logic [15:0] ALPHA_RESET = 16'd64225;

    localparam logic signed [19:0] PI_Q13 = 20'sd25736;
    localparam logic signed [19:0] TWO_PI_Q13 = 20'sd51472;
    localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [39:0] GAIN_Q30 = 40'sd652032874;
    localparam logic signed [47:0] ONE_Q14 = 48'sd16384;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic [15:0]        interval;
    } t_imu_in;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } t_imu_out;

    typedef enum logic {
        CM_VECTOR,
        CM_ROTATE
    } t_cmode;

    typedef struct packed {
        logic               start;
        t_cmode             mode;
        logic signed [39:0] x;
        logic signed [39:0] y;
        logic signed [15:0] angle;
    } t_cordic_req;

    typedef struct packed {
        logic               done;
        logic signed [15:0] angle;
        logic signed [15:0] sin_v;
        logic signed [15:0] cos_v;
    } t_cordic_rsp;

    function automatic logic [29:0] atan_tab(input logic [4:0] idx);
        logic [29:0] v;
        unique case (idx)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] wrap_q13(input logic signed [19:0] v);
        logic signed [19:0] a;
        logic signed [19:0] b;
        if (v >= PI_Q13) begin
            a = v - TWO_PI_Q13;
        end else if (v < -PI_Q13) begin
            a = v + TWO_PI_Q13;
        end else begin
            a = v;
        end
        if (a >= PI_Q13) begin
            b = a - TWO_PI_Q13;
        end else if (a < -PI_Q13) begin
            b = a + TWO_PI_Q13;
        end else begin
            b = a;
        end
        return b[15:0];
    endfunction

    function automatic logic signed [15:0] clamp_q14(input logic signed [47:0] v);
        logic signed [15:0] r;
        if (v > ONE_Q14) begin
            r = 16'sd16384;
        end else if (v < -ONE_Q14) begin
            r = -16'sd16384;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/imu_complementary_attitude_top.sv */
// From the input transfer to the result: the square root, five CORDIC runs, 23 passes
// through the one shared multiplier with their drain steps, and the load of the result
// register. One sample at a time: a new sample is taken only once the last one is done;
// a result that is not taken holds the next sample in its last step.
// Reset (synchronous, active low) clears the held angles and the sequencer and loads
// the default blend weight. Depends on imuca_pkg, imuca_cordic and the macros header.
`include "imu_complementary_attitude_top_macros.svh"

module imu_complementary_attitude_top
    import imuca_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_imu_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_imu_out    o_out_data,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DRAIN, S_SQRT, S_ROLL, S_PITCH,
        S_SROLL, S_SPITCH, S_SYAW, S_OUT
    } t_state;

    typedef enum logic [4:0] {
        MS_AY2, MS_AZ2, MS_DROLL, MS_DPITCH, MS_DYAW, MS_BR_G, MS_BR_A, MS_BP_G,
        MS_BP_A, MS_CYCP, MS_T1, MS_T2, MS_M01_A, MS_M01_B, MS_M02_A, MS_M02_B,
        MS_SYCP, MS_M11_A, MS_M11_B, MS_M12_A, MS_M12_B, MS_CPSR, MS_CPCR
    } t_mstep;

    t_state             r_state;
    t_mstep             r_step;
    t_mstep             r_ps;
    logic               r_pv;
    logic               r_cgo;
    logic [15:0]        r_alpha;
    t_imu_in            r_in;
    logic signed [51:0] r_prod;
    logic signed [47:0] r_acc;
    logic [59:0]        r_rem;
    logic [59:0]        r_res;
    logic [59:0]        r_bit;
    logic signed [15:0] r_roll_a;
    logic signed [15:0] r_pitch_a;
    logic signed [15:0] r_gr;
    logic signed [15:0] r_gp;
    logic signed [15:0] r_roll;
    logic signed [15:0] r_pitch;
    logic signed [15:0] r_yaw;
    logic signed [15:0] r_sr;
    logic signed [15:0] r_cr;
    logic signed [15:0] r_sp;
    logic signed [15:0] r_cp;
    logic signed [15:0] r_sy;
    logic signed [15:0] r_cy;
    logic signed [33:0] r_t1;
    logic signed [33:0] r_t2;
    logic signed [15:0] r_m00;
    logic signed [15:0] r_m01;
    logic signed [15:0] r_m02;
    logic signed [15:0] r_m10;
    logic signed [15:0] r_m11;
    logic signed [15:0] r_m12;
    logic signed [15:0] r_m21;
    logic signed [15:0] r_m22;
    logic               r_ovalid;
    t_imu_out           r_out;

    logic               n_cgo;
    logic               n_ovalid;
    logic signed [33:0] w_ma;
    logic signed [17:0] w_mb;
    logic               w_first;
    logic               w_sub;
    logic signed [47:0] w_acc;
    logic signed [47:0] w_r15;
    logic signed [47:0] w_r16;
    logic signed [47:0] w_r14;
    logic signed [47:0] w_r28;
    logic signed [15:0] w_q14;
    logic signed [15:0] w_q28;
    logic signed [19:0] w_delta;
    logic [59:0]        w_rb;
    t_cordic_req        w_creq;
    t_cordic_rsp        w_crsp;

    imuca_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_creq),
        .o_rsp  (w_crsp)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    always_comb begin
        w_creq.start = r_cgo;
        w_creq.mode  = CM_ROTATE;
        w_creq.x     = '0;
        w_creq.y     = '0;
        w_creq.angle = r_roll;
        unique case (r_state)
            S_ROLL: begin
                w_creq.mode = CM_VECTOR;
                w_creq.x    = 40'($signed(r_in.accel_z)) <<< 14;
                w_creq.y    = 40'($signed(r_in.accel_y)) <<< 14;
            end
            S_PITCH: begin
                w_creq.mode = CM_VECTOR;
                w_creq.x    = $signed(40'(r_res[30:0]));
                w_creq.y    = -(40'($signed(r_in.accel_x)) <<< 14);
            end
            S_SPITCH: w_creq.angle = r_pitch;
            S_SYAW:   w_creq.angle = r_yaw;
            default:  w_creq.angle = r_roll;
        endcase
    end

    always_comb begin
        unique case (r_step)
            MS_AY2:    begin w_ma = 34'($signed(r_in.accel_y)); w_mb = 18'($signed(r_in.accel_y)); end
            MS_AZ2:    begin w_ma = 34'($signed(r_in.accel_z)); w_mb = 18'($signed(r_in.accel_z)); end
            MS_DROLL:  begin w_ma = 34'($signed(r_in.rate_x)); w_mb = $signed(18'(r_in.interval)); end
            MS_DPITCH: begin w_ma = 34'($signed(r_in.rate_y)); w_mb = $signed(18'(r_in.interval)); end
            MS_DYAW:   begin w_ma = 34'($signed(r_in.rate_z)); w_mb = $signed(18'(r_in.interval)); end
            MS_BR_G:   begin w_ma = $signed(34'(r_alpha)); w_mb = 18'(r_gr); end
            MS_BR_A:   begin w_ma = 34'sd65536 - $signed(34'(r_alpha)); w_mb = 18'(r_roll_a); end
            MS_BP_G:   begin w_ma = $signed(34'(r_alpha)); w_mb = 18'(r_gp); end
            MS_BP_A:   begin w_ma = 34'sd65536 - $signed(34'(r_alpha)); w_mb = 18'(r_pitch_a); end
            MS_CYCP:   begin w_ma = 34'(r_cy); w_mb = 18'(r_cp); end
            MS_T1:     begin w_ma = 34'(r_cy); w_mb = 18'(r_sp); end
            MS_T2:     begin w_ma = 34'(r_sy); w_mb = 18'(r_sp); end
            MS_M01_A:  begin w_ma = r_t1; w_mb = 18'(r_sr); end
            MS_M01_B:  begin w_ma = 34'(r_sy) <<< 14; w_mb = 18'(r_cr); end
            MS_M02_A:  begin w_ma = r_t1; w_mb = 18'(r_cr); end
            MS_M02_B:  begin w_ma = 34'(r_sy) <<< 14; w_mb = 18'(r_sr); end
            MS_SYCP:   begin w_ma = 34'(r_sy); w_mb = 18'(r_cp); end
            MS_M11_A:  begin w_ma = r_t2; w_mb = 18'(r_sr); end
            MS_M11_B:  begin w_ma = 34'(r_cy) <<< 14; w_mb = 18'(r_cr); end
            MS_M12_A:  begin w_ma = r_t2; w_mb = 18'(r_cr); end
            MS_M12_B:  begin w_ma = 34'(r_cy) <<< 14; w_mb = 18'(r_sr); end
            MS_CPSR:   begin w_ma = 34'(r_cp); w_mb = 18'(r_sr); end
            MS_CPCR:   begin w_ma = 34'(r_cp); w_mb = 18'(r_cr); end
            default:   begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_first = !(r_ps == MS_AZ2 || r_ps == MS_BR_A || r_ps == MS_BP_A ||
                       r_ps == MS_M01_B || r_ps == MS_M02_B || r_ps == MS_M11_B ||
                       r_ps == MS_M12_B);
    assign w_sub   = (r_ps == MS_M01_B) || (r_ps == MS_M12_B);
    assign w_acc   = w_sub ? ((w_first ? 48'sd0 : r_acc) - r_prod[47:0])
                           : ((w_first ? 48'sd0 : r_acc) + r_prod[47:0]);
    assign w_r15   = w_acc + 48'sd16384;
    assign w_r16   = w_acc + 48'sd32768;
    assign w_r14   = w_acc + 48'sd8192;
    assign w_r28   = w_acc + 48'sd134217728;
    assign w_delta = $signed(w_r15[34:15]);
    assign w_q14   = clamp_q14(w_r14 >>> 14);
    assign w_q28   = clamp_q14(w_r28 >>> 28);
    assign w_rb    = r_res + r_bit;

    assign n_cgo    = (r_state == S_SQRT && r_bit == '0) ||
                      (r_state == S_DRAIN && r_ps == MS_BP_A) ||
                      ((r_state == S_ROLL || r_state == S_SROLL || r_state == S_SPITCH) &&
                       w_crsp.done);
    assign n_ovalid = (r_state == S_OUT) ? 1'b1 : (r_ovalid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= MS_AY2;
            r_ps     <= MS_AY2;
            r_pv     <= 1'b0;
            r_cgo    <= 1'b0;
            r_alpha  <= ALPHA_RESET;
            r_roll   <= '0;
            r_pitch  <= '0;
            r_yaw    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_cgo    <= n_cgo;
            r_pv     <= (r_state == S_MUL);
            r_ovalid <= n_ovalid;
            if (i_cfg_wr_en) begin
                r_alpha <= i_cfg_wr_data;
            end

            if (r_pv) begin
                r_acc <= w_acc;
                unique case (r_ps)
                    MS_DROLL:  r_gr    <= wrap_q13(20'(r_roll) + w_delta);
                    MS_DPITCH: r_gp    <= wrap_q13(20'(r_pitch) + w_delta);
                    MS_DYAW:   r_yaw   <= wrap_q13(20'(r_yaw) + w_delta);
                    MS_BR_A:   r_roll  <= w_r16[31:16];
                    MS_BP_A:   r_pitch <= w_r16[31:16];
                    MS_CYCP:   r_m00   <= w_q14;
                    MS_T1:     r_t1    <= w_acc[33:0];
                    MS_T2:     r_t2    <= w_acc[33:0];
                    MS_M01_B:  r_m01   <= w_q28;
                    MS_M02_B:  r_m02   <= w_q28;
                    MS_SYCP:   r_m10   <= w_q14;
                    MS_M11_B:  r_m11   <= w_q28;
                    MS_M12_B:  r_m12   <= w_q28;
                    MS_CPSR:   r_m21   <= w_q14;
                    MS_CPCR:   r_m22   <= w_q14;
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_step  <= MS_AY2;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= w_ma * w_mb;
                    r_ps   <= r_step;
                    if (r_step == MS_AZ2 || r_step == MS_BP_A || r_step == MS_CPCR) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_step <= t_mstep'(r_step + 5'd1);
                    end
                end
                S_DRAIN: begin
                    if (r_ps == MS_AZ2) begin
                        r_rem   <= {w_acc[31:0], 28'd0};
                        r_res   <= '0;
                        r_bit   <= 60'd1 << 58;
                        r_state <= S_SQRT;
                    end else if (r_ps == MS_BP_A) begin
                        r_state <= S_SROLL;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SQRT: begin
                    if (r_bit == '0) begin
                        r_state <= S_ROLL;
                    end else begin
                        if (r_rem >= w_rb) begin
                            r_rem <= r_rem - w_rb;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_ROLL: begin
                    if (w_crsp.done) begin
                        r_roll_a <= w_crsp.angle;
                        r_state  <= S_PITCH;
                    end
                end
                S_PITCH: begin
                    if (w_crsp.done) begin
                        r_pitch_a <= w_crsp.angle;
                        r_step    <= MS_DROLL;
                        r_state   <= S_MUL;
                    end
                end
                S_SROLL: begin
                    if (w_crsp.done) begin
                        r_sr    <= w_crsp.sin_v;
                        r_cr    <= w_crsp.cos_v;
                        r_state <= S_SPITCH;
                    end
                end
                S_SPITCH: begin
                    if (w_crsp.done) begin
                        r_sp    <= w_crsp.sin_v;
                        r_cp    <= w_crsp.cos_v;
                        r_state <= S_SYAW;
                    end
                end
                S_SYAW: begin
                    if (w_crsp.done) begin
                        r_sy    <= w_crsp.sin_v;
                        r_cy    <= w_crsp.cos_v;
                        r_step  <= MS_CYCP;
                        r_state <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_out.roll_angle  <= r_roll;
                        r_out.pitch_angle <= r_pitch;
                        r_out.yaw_angle   <= r_yaw;
                        r_out.m00         <= r_m00;
                        r_out.m01         <= r_m01;
                        r_out.m02         <= r_m02;
                        r_out.m10         <= r_m10;
                        r_out.m11         <= r_m11;
                        r_out.m12         <= r_m12;
                        r_out.m20         <= -r_sp;
                        r_out.m21         <= r_m21;
                        r_out.m22         <= r_m22;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `IMUCA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready after transfer")
    `IMUCA_ASSERT_NOW(a_mul_issue, r_pv, $past(r_state) == S_MUL, "product without issue")
    `IMUCA_ASSERT_NOW(a_sqrt_bit, r_state == S_SQRT, $onehot0(r_bit), "square root bit not one-hot")
    `IMUCA_ASSERT_NOW(a_cordic_state, r_cgo, r_state == S_ROLL || r_state == S_PITCH ||
        r_state == S_SROLL || r_state == S_SPITCH || r_state == S_SYAW, "CORDIC start outside its states")

endmodule

/* hw/rtl/imuca_cordic.sv */
// Iterative CORDIC shared by the estimator: vectoring gives atan2 in Q3.13,
// rotation gives sine and cosine in Q1.14. Depends on imuca_pkg and the macros header.
`include "imu_complementary_attitude_top_macros.svh"

module imuca_cordic
    import imuca_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_rsp o_rsp
);

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic               r_busy;
    logic               r_done;
    logic               r_vec;
    logic               r_neg;
    logic               r_zero;
    logic [IW-1:0]      r_i;
    logic signed [39:0] r_x;
    logic signed [39:0] r_y;
    logic signed [35:0] r_z;

    logic signed [39:0] w_dx;
    logic signed [39:0] w_dy;
    logic signed [35:0] w_ang;
    logic               w_ccw;
    logic signed [35:0] w_zrot;
    logic signed [35:0] w_zr;
    logic signed [39:0] w_xs;
    logic signed [39:0] w_ys;
    logic signed [39:0] w_xr;
    logic signed [39:0] w_yr;

    assign w_dx  = r_x >>> r_i;
    assign w_dy  = r_y >>> r_i;
    assign w_ang = $signed(36'(atan_tab(5'(r_i))));
    assign w_ccw = r_vec ? !(!r_y[39] && (r_y != 40'sd0)) : !r_z[35];
    assign w_zrot = 36'(i_req.angle) <<< 17;

    assign w_zr = r_z + 36'sd65536;
    assign w_xs = r_neg ? -r_x : r_x;
    assign w_ys = r_neg ? -r_y : r_y;
    assign w_xr = w_xs + 40'sd32768;
    assign w_yr = w_ys + 40'sd32768;

    always_comb begin
        o_rsp.done  = r_done;
        o_rsp.angle = r_zero ? 16'sd0 : wrap_q13(20'($signed(w_zr[35:17])));
        o_rsp.cos_v = clamp_q14(48'(w_xr >>> 16));
        o_rsp.sin_v = clamp_q14(48'(w_yr >>> 16));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_i == IW'(CORDIC_STEPS - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_vec  <= (i_req.mode == CM_VECTOR);
                r_zero <= (i_req.mode == CM_VECTOR) && (i_req.x == 40'sd0) &&
                          (i_req.y == 40'sd0);
                if (i_req.mode == CM_VECTOR) begin
                    r_neg <= 1'b0;
                    if (i_req.x[39]) begin
                        r_x <= -i_req.x;
                        r_y <= -i_req.y;
                        r_z <= i_req.y[39] ? -PI_Q30 : PI_Q30;
                    end else begin
                        r_x <= i_req.x;
                        r_y <= i_req.y;
                        r_z <= '0;
                    end
                end else begin
                    r_x <= GAIN_Q30;
                    r_y <= '0;
                    if (w_zrot > HALF_PI_Q30) begin
                        r_z   <= w_zrot - PI_Q30;
                        r_neg <= 1'b1;
                    end else if (w_zrot < -HALF_PI_Q30) begin
                        r_z   <= w_zrot + PI_Q30;
                        r_neg <= 1'b1;
                    end else begin
                        r_z   <= w_zrot;
                        r_neg <= 1'b0;
                    end
                end
            end else if (r_busy) begin
                if (w_ccw) begin
                    r_x <= r_x - w_dy;
                    r_y <= r_y + w_dx;
                    r_z <= r_z - w_ang;
                end else begin
                    r_x <= r_x + w_dy;
                    r_y <= r_y - w_dx;
                    r_z <= r_z + w_ang;
                end
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    `IMUCA_ASSERT_NOW(a_start_idle, i_req.start, !r_busy, "CORDIC started while busy")
    `IMUCA_ASSERT_NEXT(a_done_idle, r_done, !r_busy || $past(i_req.start), "busy after done")
    `IMUCA_ASSERT_NOW(a_done_after_busy, r_done, $past(r_busy), "done without iterations")

endmodule
